// ===== sv/ppt_pkg.sv =====
`default_nettype none
package ppt_pkg;

	// fixed-point format
	localparam int FRAC_BITS = 16;

	// field widths
	localparam int COORD_W    = 32;
	localparam int SCALE_W    = 24;
	localparam int SIZE_W     = 13;
	localparam int W_W        = COORD_W + 1;
	localparam int PROD_W     = SCALE_W + COORD_W + 1;
	localparam int NUM_W      = SCALE_W + COORD_W - 1;
	localparam int DEN_W      = COORD_W;
	localparam int NDC_W      = NUM_W + 1;
	localparam int SUM_W      = NUM_W + 2;
	localparam int T_W        = 35;
	localparam int R_W        = T_W + SIZE_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	// pipeline depth of one lane: multiply, magnitude, divider, four post stages
	localparam int LAT = NUM_W + 6;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_X       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd3;

	// register reset values
	localparam logic [SCALE_W-1:0] SCALE_RST  = 24'd65536;
	localparam logic [SIZE_W-1:0]  WIDTH_RST  = 13'd800;
	localparam logic [SIZE_W-1:0]  HEIGHT_RST = 13'd600;

	// ndc offset and clamp limit
	localparam logic signed [SUM_W-1:0] ONE     = SUM_W'(1) <<< FRAC_BITS;
	localparam logic signed [SUM_W-1:0] T_LIMIT = SUM_W'(1) <<< 33;
	localparam logic signed [R_W-1:0]   OUT_MAX = R_W'(64'sd2147483647);
	localparam logic signed [R_W-1:0]   OUT_MIN = -R_W'(64'sd2147483648);

	// one divider stage
	typedef struct packed {
		logic [DEN_W-1:0] rem;
		logic [NUM_W-1:0] numq;
		logic [DEN_W-1:0] den;
		logic             neg;
		logic             zero;
	} div_t;

endpackage
`default_nettype wire

// ===== sv/ppt_if.sv =====
`default_nettype none
interface ppt_tri_if;
	logic        valid;
	logic        ready;
	logic signed [31:0] ax;
	logic signed [31:0] ay;
	logic signed [31:0] az;
	logic signed [31:0] bx;
	logic signed [31:0] by;
	logic signed [31:0] bz;
	logic signed [31:0] cx;
	logic signed [31:0] cy;
	logic signed [31:0] cz;
	logic        last_in;
	modport source(output valid, ax, ay, az, bx, by, bz, cx, cy, cz, last_in, input ready);
	modport sink(input valid, ax, ay, az, bx, by, bz, cx, cy, cz, last_in, output ready);
endinterface

interface ppt_scr_if;
	logic        valid;
	logic        ready;
	logic signed [31:0] sa_x;
	logic signed [31:0] sa_y;
	logic signed [31:0] sb_x;
	logic signed [31:0] sb_y;
	logic signed [31:0] sc_x;
	logic signed [31:0] sc_y;
	logic [2:0]  w_zero_mask;
	logic        last_out;
	modport source(output valid, sa_x, sa_y, sb_x, sb_y, sc_x, sc_y, w_zero_mask, last_out,
		input ready);
	modport sink(input valid, sa_x, sa_y, sb_x, sb_y, sc_x, sc_y, w_zero_mask, last_out,
		output ready);
endinterface

interface ppt_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [23:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/perspective_project_triangle_core.sv =====
`default_nettype none
// Projects one triangle per word: each of the three camera-space vertices is divided by
// w = -z, scaled and mapped to the viewport, giving saturated Q16.16 screen x and y plus
// a mask of vertices whose w was zero (those map to the viewport centre). Six lanes run
// side by side, one per vertex and axis, each with a 55-stage radix-2 divider; a new
// triangle is taken every cycle unless a waiting output word stalls the pipeline; its result
// passes the multiply, magnitude, divider and four post stages, then the output register.
// Register writes are taken at any time but must only be made while no triangle is in flight.
module perspective_project_triangle_core (
	input  wire logic clk,
	input  wire logic arst_n,
	ppt_tri_if.sink   tri_in,
	ppt_scr_if.source scr_out,
	ppt_cfg_if.sink   cfg
);

	logic [ppt_pkg::SCALE_W-1:0] scale_x_q;
	logic [ppt_pkg::SCALE_W-1:0] scale_y_q;
	logic [ppt_pkg::SIZE_W-1:0]  width_q;
	logic [ppt_pkg::SIZE_W-1:0]  height_q;
	logic [ppt_pkg::LAT-1:0]     vld_q;
	logic [ppt_pkg::LAT-1:0]     last_q;
	logic                        ovld_q;
	logic                        en;
	logic                        load;
	logic signed [ppt_pkg::COORD_W-1:0] lane_scr [0:5];
	logic [5:0]                  lane_zero;

	// register writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_x_q <= ppt_pkg::SCALE_RST;
			scale_y_q <= ppt_pkg::SCALE_RST;
			width_q   <= ppt_pkg::WIDTH_RST;
			height_q  <= ppt_pkg::HEIGHT_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				ppt_pkg::REG_SCALE_X:       scale_x_q <= cfg.data;
				ppt_pkg::REG_SCALE_Y:       scale_y_q <= cfg.data;
				ppt_pkg::REG_SCREEN_WIDTH:  width_q   <= cfg.data[ppt_pkg::SIZE_W-1:0];
				ppt_pkg::REG_SCREEN_HEIGHT: height_q  <= cfg.data[ppt_pkg::SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// pipeline moves unless its last stage is blocked by a waiting word
	assign en           = !vld_q[ppt_pkg::LAT-1] || !ovld_q || scr_out.ready;
	assign load         = en && vld_q[ppt_pkg::LAT-1];
	assign tri_in.ready = en;

	// valid and last tags beside the lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[ppt_pkg::LAT-2:0], tri_in.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_q <= {last_q[ppt_pkg::LAT-2:0], tri_in.last_in};
		end
	end

	// six lanes: vertex one, two, three; x then y
	ppt_lane u_ax (.clk(clk), .en(en), .coord(tri_in.ax), .z(tri_in.az), .scale(scale_x_q),
		.size(width_q), .screen(lane_scr[0]), .w_zero(lane_zero[0]));
	ppt_lane u_ay (.clk(clk), .en(en), .coord(tri_in.ay), .z(tri_in.az), .scale(scale_y_q),
		.size(height_q), .screen(lane_scr[1]), .w_zero(lane_zero[1]));
	ppt_lane u_bx (.clk(clk), .en(en), .coord(tri_in.bx), .z(tri_in.bz), .scale(scale_x_q),
		.size(width_q), .screen(lane_scr[2]), .w_zero(lane_zero[2]));
	ppt_lane u_by (.clk(clk), .en(en), .coord(tri_in.by), .z(tri_in.bz), .scale(scale_y_q),
		.size(height_q), .screen(lane_scr[3]), .w_zero(lane_zero[3]));
	ppt_lane u_cx (.clk(clk), .en(en), .coord(tri_in.cx), .z(tri_in.cz), .scale(scale_x_q),
		.size(width_q), .screen(lane_scr[4]), .w_zero(lane_zero[4]));
	ppt_lane u_cy (.clk(clk), .en(en), .coord(tri_in.cy), .z(tri_in.cz), .scale(scale_y_q),
		.size(height_q), .screen(lane_scr[5]), .w_zero(lane_zero[5]));

	// merge lanes into the output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if (load) begin
			ovld_q <= 1'b1;
		end else if (scr_out.ready) begin
			ovld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			scr_out.sa_x        <= lane_scr[0];
			scr_out.sa_y        <= lane_scr[1];
			scr_out.sb_x        <= lane_scr[2];
			scr_out.sb_y        <= lane_scr[3];
			scr_out.sc_x        <= lane_scr[4];
			scr_out.sc_y        <= lane_scr[5];
			scr_out.w_zero_mask <= {lane_zero[4], lane_zero[2], lane_zero[0]};
			scr_out.last_out    <= last_q[ppt_pkg::LAT-1];
		end
	end

	assign scr_out.valid = ovld_q;

endmodule
`default_nettype wire

// ===== sv/ppt_div_step.sv =====
`default_nettype none
module ppt_div_step (
	input  wire logic       clk,
	input  wire logic       en,
	input  ppt_pkg::div_t   d_i,
	output ppt_pkg::div_t   d_o
);

	logic [ppt_pkg::DEN_W:0]   partial;
	logic [ppt_pkg::DEN_W+1:0] diff;
	logic                      fits;

	// one restoring step: shift in the next numerator bit and try the subtract
	always_comb begin
		partial = {d_i.rem, d_i.numq[ppt_pkg::NUM_W-1]};
		diff    = {1'b0, partial} - {2'b00, d_i.den};
		fits    = !diff[ppt_pkg::DEN_W+1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_o.rem  <= fits ? diff[ppt_pkg::DEN_W-1:0] : partial[ppt_pkg::DEN_W-1:0];
			d_o.numq <= {d_i.numq[ppt_pkg::NUM_W-2:0], fits};
			d_o.den  <= d_i.den;
			d_o.neg  <= d_i.neg;
			d_o.zero <= d_i.zero;
		end
	end

endmodule
`default_nettype wire

// ===== sv/ppt_lane.sv =====
`default_nettype none
module ppt_lane (
	input  wire logic                                 clk,
	input  wire logic                                 en,
	input  wire logic signed [ppt_pkg::COORD_W-1:0]   coord,
	input  wire logic signed [ppt_pkg::COORD_W-1:0]   z,
	input  wire logic [ppt_pkg::SCALE_W-1:0]          scale,
	input  wire logic [ppt_pkg::SIZE_W-1:0]           size,
	output logic signed [ppt_pkg::COORD_W-1:0]        screen,
	output logic                                      w_zero
);

	logic signed [ppt_pkg::PROD_W-1:0] prod_s1;
	logic signed [ppt_pkg::W_W-1:0]    w_s1;
	logic signed [ppt_pkg::PROD_W-1:0] prod_abs;
	logic signed [ppt_pkg::W_W-1:0]    w_abs;
	ppt_pkg::div_t                     stage_q [0:ppt_pkg::NUM_W];
	ppt_pkg::div_t                     dq;
	logic signed [ppt_pkg::NDC_W-1:0]  ndc_s3;
	logic                              zero_s3;
	logic signed [ppt_pkg::SUM_W-1:0]  t_sum;
	logic signed [ppt_pkg::T_W-1:0]    t_s4;
	logic                              zero_s4;
	logic signed [ppt_pkg::R_W-1:0]    r_s5;
	logic                              zero_s5;
	logic signed [ppt_pkg::R_W-1:0]    half;

	// product and divisor
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= ppt_pkg::PROD_W'($signed({1'b0, scale}))
				* ppt_pkg::PROD_W'(coord);
			w_s1    <= -ppt_pkg::W_W'(z);
		end
	end

	// magnitudes and quotient sign
	always_comb begin
		prod_abs = prod_s1[ppt_pkg::PROD_W-1] ? -prod_s1 : prod_s1;
		w_abs    = w_s1[ppt_pkg::W_W-1] ? -w_s1 : w_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stage_q[0].rem  <= '0;
			stage_q[0].numq <= prod_abs[ppt_pkg::NUM_W-1:0];
			stage_q[0].den  <= w_abs[ppt_pkg::DEN_W-1:0];
			stage_q[0].neg  <= prod_s1[ppt_pkg::PROD_W-1] ^ w_s1[ppt_pkg::W_W-1];
			stage_q[0].zero <= (w_s1 == '0);
		end
	end

	// radix-2 divider, one quotient bit per stage
	for (genvar k = 0; k < ppt_pkg::NUM_W; k++) begin : g_div
		ppt_div_step u_step (
			.clk (clk),
			.en  (en),
			.d_i (stage_q[k]),
			.d_o (stage_q[k+1])
		);
	end

	assign dq = stage_q[ppt_pkg::NUM_W];

	// signed ndc, zero when w was zero
	always_ff @(posedge clk) begin
		if (en) begin
			if (dq.zero) begin
				ndc_s3 <= '0;
			end else if (dq.neg) begin
				ndc_s3 <= -$signed({1'b0, dq.numq});
			end else begin
				ndc_s3 <= $signed({1'b0, dq.numq});
			end
			zero_s3 <= dq.zero;
		end
	end

	// offset by one and clamp
	assign t_sum = ppt_pkg::SUM_W'(ndc_s3) + ppt_pkg::ONE;

	always_ff @(posedge clk) begin
		if (en) begin
			if (t_sum > ppt_pkg::T_LIMIT) begin
				t_s4 <= ppt_pkg::T_W'(ppt_pkg::T_LIMIT);
			end else if (t_sum < -ppt_pkg::T_LIMIT) begin
				t_s4 <= ppt_pkg::T_W'(-ppt_pkg::T_LIMIT);
			end else begin
				t_s4 <= t_sum[ppt_pkg::T_W-1:0];
			end
			zero_s4 <= zero_s3;
		end
	end

	// scale to viewport size
	always_ff @(posedge clk) begin
		if (en) begin
			r_s5    <= ppt_pkg::R_W'($signed({1'b0, size})) * ppt_pkg::R_W'(t_s4);
			zero_s5 <= zero_s4;
		end
	end

	// halve toward zero and saturate
	assign half = $signed(r_s5 + ppt_pkg::R_W'({1'b0, r_s5[ppt_pkg::R_W-1]})) >>> 1;

	always_ff @(posedge clk) begin
		if (en) begin
			if (half > ppt_pkg::OUT_MAX) begin
				screen <= ppt_pkg::COORD_W'(ppt_pkg::OUT_MAX);
			end else if (half < ppt_pkg::OUT_MIN) begin
				screen <= ppt_pkg::COORD_W'(ppt_pkg::OUT_MIN);
			end else begin
				screen <= half[ppt_pkg::COORD_W-1:0];
			end
			w_zero <= zero_s5;
		end
	end

endmodule
`default_nettype wire
